// File: hdl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared constants and types for the aging page-replacement core.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_PAGE_BITS   = 16;

  localparam int AGE_W        = 8;
  localparam int CFG_W        = 5;
  localparam int PAGE_FIELD_W = 16;
  localparam int SLOT_FIELD_W = 4;

  localparam logic [AGE_W-1:0] AGE_TOP   = 8'h80;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic ACT_REF  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Control from the sequencer to the victim selector
  typedef struct packed {
    logic clear;
    logic sample;
  } sel_ctl_t;

  // Outcome flags of one table scan
  typedef struct packed {
    logic found;
    logic evict;
  } sel_stat_t;

endpackage

// File: hdl/apr_if.sv
// ----------------------------------------------------------------------------
// apr_if
// Request and response channels of the aging page-replacement core.
// ----------------------------------------------------------------------------
interface apr_req_if import apr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [PAGE_FIELD_W-1:0] page_number;

  modport source (output valid, action, page_number, input ready);
  modport sink (input valid, action, page_number, output ready);
endinterface

interface apr_rsp_if import apr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    evicted_valid;
  logic [PAGE_FIELD_W-1:0] evicted_page;

  modport source (output valid, hit, slot, evicted_valid, evicted_page, input ready);
  modport sink (input valid, hit, slot, evicted_valid, evicted_page, output ready);
endinterface

// File: hdl/aging_page_replacement_core.sv
// ----------------------------------------------------------------------------
// aging_page_replacement_core
// Page-frame table with aging replacement, held in a single-port-read memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item: action 0 looks up page_number,
//   action 1 is an aging tick that halves the age of every valid active slot.
//   rsp returns one transaction per lookup (hit, slot, evicted page) and
//   none per tick. cfg_we/cfg_wdata set the number of active slots; write
//   it only while the core is idle.
// Scan (n = active slots):
//   Each item scans the n active entries of the frame memory, one read a
//   cycle, through a read port with registered data. A lookup then writes
//   its slot update and its result register, and the next transaction is
//   taken once the core is back in idle. A tick reads and writes back
//   each entry in flight.
// Reset:
//   rst clears every valid bit and sets the active count to 16; no clearing
//   pass is needed. The result sits in an output register, so a stalled
//   rsp only holds the core once a second lookup has finished its scan.
// ----------------------------------------------------------------------------
module aging_page_replacement_core import apr_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  apr_req_if.sink          req,
  apr_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = ($clog2(TABLE_SLOTS + 1) > CFG_W) ? $clog2(TABLE_SLOTS + 1) : CFG_W;
  localparam int WORD_W = PAGE_BITS + AGE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CFG_W-1:0]     entries_in_use;
  logic [CNT_W-1:0]     cfg_ext;
  logic [IDX_W-1:0]     act_last;
  logic [IDX_W-1:0]     scan_last;
  logic [PAGE_BITS-1:0] key_page;
  logic [TABLE_SLOTS-1:0] slot_valid;

  logic                 iss_vld;
  logic [IDX_W-1:0]     iss_idx;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_slot_valid;
  logic [WORD_W-1:0]    rd_word;
  logic [PAGE_BITS-1:0] rd_page;
  logic [AGE_W-1:0]     rd_age;
  logic                 rd_last;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  sel_ctl_t             sel_ctl;
  sel_stat_t            sel_stat;
  logic [IDX_W-1:0]     sel_target;
  logic [AGE_W-1:0]     sel_new_age;
  logic [PAGE_BITS-1:0] sel_evict_page;

  logic                 accept;
  logic                 wr_go;

  logic                    out_valid;
  logic                    out_hit;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic                    out_evicted_valid;
  logic [PAGE_FIELD_W-1:0] out_evicted_page;

  // Active count, with zero acting as one and overflow clamped
  always_comb begin
    cfg_ext = CNT_W'(entries_in_use);
    priority if (cfg_ext == CNT_W'(0)) begin
      act_last = IDX_W'(0);
    end else if (cfg_ext > CNT_W'(TABLE_SLOTS)) begin
      act_last = IDX_W'(TABLE_SLOTS - 1);
    end else begin
      act_last = IDX_W'(cfg_ext - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign wr_go     = (state == ST_WRITE) && (!out_valid || rsp.ready);
  assign rd_page   = rd_word[WORD_W-1:AGE_W];
  assign rd_age    = rd_word[AGE_W-1:0];
  assign rd_last   = rd_vld && (rd_idx == scan_last);

  always_ff @(posedge clk) begin
    if (accept) begin
      key_page  <= PAGE_BITS'(req.page_number);
      scan_last <= act_last;
    end
  end

  // Read issue and response pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_vld <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= iss_vld;
      if (accept) begin
        iss_vld <= 1'b1;
      end else if (iss_vld && iss_idx == scan_last) begin
        iss_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss_idx <= IDX_W'(0);
    end else if (iss_vld && iss_idx != scan_last) begin
      iss_idx <= iss_idx + IDX_W'(1);
    end
    rd_idx        <= iss_idx;
    rd_slot_valid <= slot_valid[iss_idx];
  end

  apr_frame_mem #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (iss_idx),
    .rdata (rd_word)
  );

  assign sel_ctl.clear  = accept;
  assign sel_ctl.sample = rd_vld && (state == ST_SCAN);

  apr_victim_sel #(
    .IDX_W  (IDX_W),
    .PAGE_W (PAGE_BITS)
  ) u_sel (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sel_ctl),
    .smp_idx    (rd_idx),
    .smp_valid  (rd_slot_valid),
    .smp_page   (rd_page),
    .smp_age    (rd_age),
    .key_page   (key_page),
    .stat       (sel_stat),
    .target     (sel_target),
    .new_age    (sel_new_age),
    .evict_page (sel_evict_page)
  );

  // Write port: age write-back during a tick, slot update after a lookup
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = {rd_page, rd_age >> 1};
    if (state == ST_TICK) begin
      mem_we = rd_vld && rd_slot_valid;
    end else if (wr_go) begin
      mem_we    = 1'b1;
      mem_waddr = sel_target;
      mem_wdata = {key_page, sel_new_age};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_go) begin
      slot_valid[sel_target] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == ACT_TICK) ? ST_TICK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_TICK: begin
        if (rd_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: begin
        if (wr_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_hit           <= sel_stat.found;
      out_slot          <= SLOT_FIELD_W'(sel_target);
      out_evicted_valid <= sel_stat.evict;
      out_evicted_page  <= sel_stat.evict ? PAGE_FIELD_W'(sel_evict_page) : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.slot          = out_slot;
  assign rsp.evicted_valid = out_evicted_valid;
  assign rsp.evicted_page  = out_evicted_page;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_we && iss_vld) |-> (mem_waddr != iss_idx))
    else $error("frame memory written and read at the same entry");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (rd_idx <= scan_last))
    else $error("scan read beyond the active slots");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WRITE))
    else $error("result raised outside the slot update");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_hit) |-> (!out_evicted_valid && out_evicted_page == '0))
    else $error("hit reported with an eviction");

  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    wr_go |=> slot_valid[$past(sel_target)])
    else $error("updated slot not marked valid");
`endif

endmodule

// File: hdl/apr_frame_mem.sv
// ----------------------------------------------------------------------------
// apr_frame_mem
// Frame table store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module apr_frame_mem import apr_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_SLOTS,
  parameter int WIDTH = DEF_PAGE_BITS + AGE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/apr_victim_sel.sv
// ----------------------------------------------------------------------------
// apr_victim_sel
// Scan accumulator: tracks the first hit, the first empty slot and the
// oldest slot as table entries stream past, and picks the target slot.
// ----------------------------------------------------------------------------
module apr_victim_sel import apr_pkg::*; #(
  parameter int IDX_W  = 4,
  parameter int PAGE_W = DEF_PAGE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  sel_ctl_t          ctl,
  input  logic [IDX_W-1:0]  smp_idx,
  input  logic              smp_valid,
  input  logic [PAGE_W-1:0] smp_page,
  input  logic [AGE_W-1:0]  smp_age,
  input  logic [PAGE_W-1:0] key_page,
  output sel_stat_t         stat,
  output logic [IDX_W-1:0]  target,
  output logic [AGE_W-1:0]  new_age,
  output logic [PAGE_W-1:0] evict_page
);

  logic              found;
  logic              empty_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [AGE_W-1:0]  hit_age;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  min_idx;
  logic [AGE_W-1:0]  min_age;
  logic [PAGE_W-1:0] min_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (ctl.clear) begin
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (ctl.sample) begin
      if (!found && smp_valid && smp_page == key_page) begin
        found <= 1'b1;
      end
      if (!empty_found && !smp_valid) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      if (!found && smp_valid && smp_page == key_page) begin
        hit_idx <= smp_idx;
        hit_age <= smp_age;
      end
      if (!empty_found && !smp_valid) begin
        empty_idx <= smp_idx;
      end
      // strict compare keeps the lowest index on a tie
      if (smp_idx == IDX_W'(0) || smp_age < min_age) begin
        min_idx  <= smp_idx;
        min_age  <= smp_age;
        min_page <= smp_page;
      end
    end
  end

  always_comb begin
    stat.found = found;
    stat.evict = !found && !empty_found;
    evict_page = min_page;
    priority if (found) begin
      target  = hit_idx;
      new_age = hit_age | AGE_TOP;
    end else if (empty_found) begin
      target  = empty_idx;
      new_age = AGE_TOP;
    end else begin
      target  = min_idx;
      new_age = AGE_TOP;
    end
  end

endmodule
